// ===== hw/rtl/skf_pkg.sv =====
// Shared types and constants for the scalar Kalman filter.
// Holds the controller/datapath command and status structs and the register map.
// No dependencies.
`default_nettype none

package skf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ERROR = 2'd2;

    localparam logic [31:0] PROCESS_NOISE_RST = 32'd50332;
    localparam logic [31:0] MEASURE_NOISE_RST = 32'd335544320;
    localparam logic [31:0] INITIAL_ERROR_RST = 32'd1678;

    localparam int SAMPLE_W   = 24;
    localparam int FILTERED_W = 32;
    localparam int GAIN_W     = 25;
    localparam logic [GAIN_W-1:0] ONE_Q24 = 25'h100_0000;

    localparam int DIV_REM_W  = 33;
    localparam int DIV_NUM_W  = 25;
    localparam int DIV_STEP_W = 5;
    localparam logic [DIV_STEP_W-1:0] DIV_GAIN_STEPS = 5'd25;

    typedef struct packed {
        logic load_sample;
        logic seed_start;
        logic seed_rem;
        logic seed_load;
        logic pmid_load;
        logic div_start;
        logic gain_load;
        logic mul_est;
        logic est_update;
        logic mul_cov;
        logic cov_update;
        logic out_load;
    } skf_cmd_t;

    typedef struct packed {
        logic warm_active;
        logic warm_last;
        logic div_busy;
        logic div_done;
    } skf_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skf_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Uses skf_pkg for widths; instantiated by skf_dp.
`default_nettype none

module skf_div
    import skf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIV_REM_W-1:0]  rem_init,
    input  wire logic [DIV_NUM_W-1:0]  num_low,
    input  wire logic [DIV_REM_W-1:0]  divisor,
    input  wire logic [DIV_STEP_W-1:0] steps,
    output logic      [DIV_NUM_W-1:0]  quotient,
    output logic                       busy,
    output logic                       done
);

    logic [DIV_REM_W-1:0]  rem_reg, rem_next;
    logic [DIV_NUM_W-1:0]  num_reg, num_next;
    logic [DIV_NUM_W-1:0]  quo_reg, quo_next;
    logic [DIV_REM_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_STEP_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_REM_W:0]    trial;
    logic [DIV_REM_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = rem_init;
            num_next  = num_low;
            quo_next  = '0;
            dvs_next  = divisor;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
            num_next = {num_reg[DIV_NUM_W-2:0], 1'b0};
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/skf_dp.sv =====
// Datapath of the scalar Kalman filter: configuration, filter state,
// shared multiplier and output registers. Uses skf_pkg and skf_div.
`default_nettype none

module skf_dp
    import skf_pkg::*;
#(
    parameter int WARMUP_SAMPLES = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [SAMPLE_W-1:0]   sample,
    output logic [FILTERED_W-1:0]      filtered,
    output logic                       warming_up,
    input  wire skf_cmd_t              cmd,
    output skf_status_t                status
);

    localparam int CNT_W   = $clog2(WARMUP_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_W + CNT_W;
    localparam int SEED_L  = $clog2(WARMUP_SAMPLES);
    localparam int SEED_K1 = SUM_W - 1 + SEED_L;
    localparam int FRAC_N  = 8 + CNT_W;
    localparam int SEED_K2 = FRAC_N + SEED_L;
    localparam logic [SUM_W:0] SEED_M1 = (SUM_W + 1)'(((64'd1 << SEED_K1)
        + 64'(WARMUP_SAMPLES) - 64'd1) / 64'(WARMUP_SAMPLES));
    localparam logic [FRAC_N+1:0] SEED_M2 = (FRAC_N + 2)'(((64'd1 << SEED_K2)
        + 64'(WARMUP_SAMPLES) - 64'd1) / 64'(WARMUP_SAMPLES));

    logic [31:0]              pq_reg, pr_reg;
    logic signed [31:0]       est_reg;
    logic [31:0]              cov_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [31:0]       samp_reg;
    logic [31:0]              pmid_reg;
    logic                     dzero_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [59:0]       prod_reg;
    logic [31:0]              result_reg;
    logic                     warm_res_reg;
    logic [31:0]              out_data_reg;
    logic                     out_warm_reg;
    logic [SAMPLE_W-1:0]      seed_q_reg;
    logic [CNT_W-1:0]         seed_rem_reg;

    logic [32:0]              pmid_sum;
    logic [32:0]              denom;
    logic [SUM_W-1:0]         abs_sum;
    logic signed [32:0]       diff;
    logic signed [25:0]       mul_a;
    logic signed [33:0]       mul_b;
    logic signed [59:0]       prod_adj;
    logic signed [59:0]       delta;
    logic [2*SUM_W:0]         seed_prod;
    logic [SUM_W-1:0]         seed_qd;
    logic [FRAC_N-1:0]        frac_num;
    logic [2*FRAC_N+1:0]      frac_prod;
    logic [7:0]               seed_frac;
    logic [31:0]              seed_mag;
    logic                     div_start;
    logic [DIV_REM_W-1:0]     div_rem_init;
    logic [DIV_NUM_W-1:0]     div_num_low;
    logic [DIV_REM_W-1:0]     div_divisor;
    logic [DIV_STEP_W-1:0]    div_steps;
    logic [DIV_NUM_W-1:0]     div_quo;
    logic                     div_busy;
    logic                     div_done;

    assign pmid_sum = {1'b0, cov_reg} + {1'b0, pq_reg};
    assign denom    = {1'b0, pmid_reg} + {1'b0, pr_reg};
    assign abs_sum  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign diff     = {samp_reg[31], samp_reg} - {est_reg[31], est_reg};
    assign mul_a    = cmd.mul_est ? signed'({1'b0, gain_reg})
                                  : signed'({1'b0, ONE_Q24 - gain_reg});
    assign mul_b    = cmd.mul_est ? {diff[32], diff} : signed'({2'b00, pmid_reg});
    assign prod_adj = prod_reg[59] ? prod_reg + 60'sd16777215 : prod_reg;
    assign delta    = prod_adj >>> 24;

    // The seed mean is split into the whole part of the sum over the sample count
    // and the eight fraction bits of the remainder, each by a reciprocal multiply.
    assign seed_prod = {{(SUM_W + 1){1'b0}}, abs_sum} * {{SUM_W{1'b0}}, SEED_M1};
    assign seed_qd   = SUM_W'(seed_q_reg) * SUM_W'(WARMUP_SAMPLES);
    assign frac_num  = {seed_rem_reg, 8'h00};
    assign frac_prod = {{(FRAC_N + 2){1'b0}}, frac_num} * {{FRAC_N{1'b0}}, SEED_M2};
    assign seed_frac = 8'(frac_prod >> SEED_K2);
    assign seed_mag  = {seed_q_reg, 8'h00} + {24'd0, seed_frac};

    assign div_start    = cmd.div_start;
    assign div_rem_init = {2'b00, pmid_reg[31:1]};
    assign div_num_low  = {pmid_reg[0], {(DIV_NUM_W - 1){1'b0}}};
    assign div_divisor  = denom;
    assign div_steps    = DIV_GAIN_STEPS;

    skf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem_init),
        .num_low  (div_num_low),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .quotient (div_quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pq_reg  <= PROCESS_NOISE_RST;
            pr_reg  <= MEASURE_NOISE_RST;
            est_reg <= '0;
            cov_reg <= INITIAL_ERROR_RST;
            cnt_reg <= '0;
            sum_reg <= '0;
        end else begin
            if (cmd.load_sample && status.warm_active) begin
                sum_reg <= sum_reg + SUM_W'(signed'(sample));
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.seed_load) begin
                est_reg <= sum_reg[SUM_W-1] ? -signed'(seed_mag) : signed'(seed_mag);
            end
            if (cmd.est_update) begin
                est_reg <= est_reg + signed'(delta[31:0]);
            end
            if (cmd.cov_update) begin
                cov_reg <= prod_reg[55:24];
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PROCESS_NOISE: pq_reg <= cfg_data;
                    CFG_MEASURE_NOISE: pr_reg <= cfg_data;
                    CFG_INITIAL_ERROR: cov_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            samp_reg     <= signed'({sample, 8'h00});
            result_reg   <= {sample, 8'h00};
            warm_res_reg <= 1'b1;
        end
        if (cmd.seed_start) begin
            seed_q_reg <= SAMPLE_W'(seed_prod >> SEED_K1);
        end
        if (cmd.seed_rem) begin
            seed_rem_reg <= CNT_W'(abs_sum - seed_qd);
        end
        if (cmd.pmid_load) begin
            pmid_reg <= pmid_sum[32] ? 32'hFFFF_FFFF : pmid_sum[31:0];
        end
        if (cmd.div_start) begin
            dzero_reg <= (pmid_reg == 32'd0) && (pr_reg == 32'd0);
        end
        if (cmd.gain_load) begin
            gain_reg <= dzero_reg ? '0 : div_quo;
        end
        if (cmd.mul_est || cmd.mul_cov) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.cov_update) begin
            result_reg   <= est_reg;
            warm_res_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_data_reg <= result_reg;
            out_warm_reg <= warm_res_reg;
        end
    end

    always_comb begin
        status.warm_active = cnt_reg < CNT_W'(WARMUP_SAMPLES);
        status.warm_last   = cnt_reg == CNT_W'(WARMUP_SAMPLES - 1);
        status.div_busy    = div_busy;
        status.div_done    = div_done;
    end

    assign filtered   = out_data_reg;
    assign warming_up = out_warm_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/skf_ctrl.sv =====
// Controller of the scalar Kalman filter: sequences warm-up, seeding and
// filter steps and owns both stream handshakes. Uses skf_pkg.
`default_nettype none

module skf_ctrl
    import skf_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output skf_cmd_t          cmd,
    input  wire skf_status_t  status
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SEED_GO   = 4'd1;
    localparam logic [3:0] ST_SEED_REM  = 4'd2;
    localparam logic [3:0] ST_SEED_LOAD = 4'd3;
    localparam logic [3:0] ST_PMID      = 4'd4;
    localparam logic [3:0] ST_DIV_GO    = 4'd5;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd6;
    localparam logic [3:0] ST_MUL_EST   = 4'd7;
    localparam logic [3:0] ST_EST       = 4'd8;
    localparam logic [3:0] ST_MUL_COV   = 4'd9;
    localparam logic [3:0] ST_COV       = 4'd10;
    localparam logic [3:0] ST_RESULT    = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_sample = 1'b1;
                    if (status.warm_last) begin
                        state_next = ST_SEED_GO;
                    end else if (status.warm_active) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_PMID;
                    end
                end
            end
            ST_SEED_GO: begin
                cmd.seed_start = 1'b1;
                state_next     = ST_SEED_REM;
            end
            ST_SEED_REM: begin
                cmd.seed_rem = 1'b1;
                state_next   = ST_SEED_LOAD;
            end
            ST_SEED_LOAD: begin
                cmd.seed_load = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_PMID: begin
                cmd.pmid_load = 1'b1;
                state_next    = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.gain_load = 1'b1;
                    state_next    = ST_MUL_EST;
                end
            end
            ST_MUL_EST: begin
                cmd.mul_est = 1'b1;
                state_next  = ST_EST;
            end
            ST_EST: begin
                cmd.est_update = 1'b1;
                state_next     = ST_MUL_COV;
            end
            ST_MUL_COV: begin
                cmd.mul_cov = 1'b1;
                state_next  = ST_COV;
            end
            ST_COV: begin
                cmd.cov_update = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("Divider started while busy.");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("Divider finished outside a wait state.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("Output register overwritten before its transaction.");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("Accepted transaction did not start processing.");

endmodule

`default_nettype wire

// ===== hw/rtl/scalar_kalman_filter_top.sv =====
// Scalar Kalman filter, one item at a time: the next item is accepted only after the
// result of the last one is loaded for output. A filtered item runs the prediction,
// the 25-step gain divider, the estimate and the covariance update in that order. Warm-up
// items return their sample without filter steps; the last warm-up item first runs the
// seed steps for the seed mean. A stalled result holds off the input until it is taken.
// Reset (aresetn, synchronous, active low) restores register defaults, clears the
// estimate and warm-up count and loads the covariance with the default initial_error.
`default_nettype none

module scalar_kalman_filter_top
    import skf_pkg::*;
#(
    parameter int WARMUP_SAMPLES = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,   // sample[23:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [31:0]           m_tdata,   // filtered[31:0]
    output logic                       m_tuser,   // warming_up[0]
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    skf_cmd_t    cmd;
    skf_status_t status;

    skf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    skf_dp #(
        .WARMUP_SAMPLES (WARMUP_SAMPLES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (s_tdata),
        .filtered   (m_tdata),
        .warming_up (m_tuser),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

`default_nettype wire
